// ----- rtl/hplh_pkg.sv -----
// Package for the homopolymer length histogram: sizes, request and status codes,
// and the decoded request struct shared by the decoder and the top level.
// No dependencies.
package hplh_pkg;

  localparam int MAX_HP     = 15;
  localparam int COUNT_BITS = 32;

  localparam int SIDE_BITS  = $clog2(MAX_HP + 1);
  localparam int ADDR_BITS  = 2 + 2 * SIDE_BITS;
  localparam int DEPTH      = 4 << (2 * SIDE_BITS);

  localparam int REQ_BITS   = 2;
  localparam int BASE_BITS  = 2;
  localparam int LEN_BITS   = 16;
  localparam int RDLEN_BITS = 4;
  localparam int MAXL_BITS  = 4;
  localparam int OUT_BITS   = 32;
  localparam int STAT_BITS  = 2;

  localparam int IN_DATA_BITS  = 40;
  localparam int OUT_DATA_BITS = 32;

  localparam logic [MAXL_BITS-1:0] MAX_LEN_RESET = 4'd15;

  localparam logic [REQ_BITS-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd2;

  localparam logic [STAT_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_REF_LONG = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_OBS_LONG = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_OBS_NEG  = 2'd3;

  typedef struct packed {
    logic                  is_add;
    logic                  is_read;
    logic                  is_clear;
    logic                  hit;      // counter access goes ahead
    logic [STAT_BITS-1:0]  status;
    logic [ADDR_BITS-1:0]  addr;
  } dec_t;

endpackage

// ----- rtl/hplh_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hplh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/hplh_decode.sv -----
// Request decoder: range checks, drop status and counter address.
// Depends on hplh_pkg.
module hplh_decode (
  input  logic [hplh_pkg::REQ_BITS-1:0]   req_type,
  input  logic [hplh_pkg::BASE_BITS-1:0]  base,
  input  logic [hplh_pkg::LEN_BITS-1:0]   ref_len,
  input  logic [hplh_pkg::LEN_BITS-1:0]   length_error,
  input  logic [hplh_pkg::RDLEN_BITS-1:0] read_len,
  input  logic [hplh_pkg::MAXL_BITS-1:0]  max_len,
  output hplh_pkg::dec_t                  dec
);

  logic [hplh_pkg::LEN_BITS-1:0]  lim;
  logic [hplh_pkg::LEN_BITS+1:0]  obs;   // two's complement, 18 bits
  logic                           obs_neg;
  logic                           obs_long;
  logic                           row_long;
  logic                           col_long;
  logic [hplh_pkg::SIDE_BITS-1:0] col;

  always_comb begin
    lim = (hplh_pkg::LEN_BITS'(max_len) < hplh_pkg::LEN_BITS'(hplh_pkg::MAX_HP))
        ? hplh_pkg::LEN_BITS'(max_len) : hplh_pkg::LEN_BITS'(hplh_pkg::MAX_HP);
    obs = {2'b00, ref_len} + {{2{length_error[hplh_pkg::LEN_BITS-1]}}, length_error};
    obs_neg  = obs[hplh_pkg::LEN_BITS+1];
    obs_long = !obs_neg && (obs[hplh_pkg::LEN_BITS:0] > {1'b0, lim});
    row_long = ref_len > lim;
    col_long = hplh_pkg::LEN_BITS'(read_len) > lim;

    dec.is_add   = 1'b0;
    dec.is_read  = 1'b0;
    dec.is_clear = 1'b0;
    dec.hit      = 1'b0;
    dec.status   = hplh_pkg::ST_OK;
    col          = obs[hplh_pkg::SIDE_BITS-1:0];

    unique case (req_type)
      hplh_pkg::REQ_ADD: begin
        dec.is_add = 1'b1;
        if (row_long) begin
          dec.status = hplh_pkg::ST_REF_LONG;
        end else if (obs_long) begin
          dec.status = hplh_pkg::ST_OBS_LONG;
        end else if (obs_neg) begin
          dec.status = hplh_pkg::ST_OBS_NEG;
        end else begin
          dec.hit = 1'b1;
        end
      end
      hplh_pkg::REQ_READ: begin
        dec.is_read = 1'b1;
        col = hplh_pkg::SIDE_BITS'(read_len);
        if (row_long) begin
          dec.status = hplh_pkg::ST_REF_LONG;
        end else if (col_long) begin
          dec.status = hplh_pkg::ST_OBS_LONG;
        end else begin
          dec.hit = 1'b1;
        end
      end
      hplh_pkg::REQ_CLEAR: begin
        dec.is_clear = 1'b1;
      end
      default: begin
      end
    endcase

    dec.addr = {base, ref_len[hplh_pkg::SIDE_BITS-1:0], col};
  end

endmodule

// ----- rtl/hplh_sweep.sv -----
// Clearing sequencer: walks every counter address once, writing zero.
// Starts after reset, on a clear request and on a max_len write. Depends on hplh_pkg.
module hplh_sweep (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  output logic [hplh_pkg::ADDR_BITS-1:0] addr
);

  logic                           busy_r, busy_nxt;
  logic [hplh_pkg::ADDR_BITS-1:0] addr_r, addr_nxt;

  always_comb begin
    busy_nxt = busy_r;
    addr_nxt = addr_r;
    if (start) begin
      busy_nxt = 1'b1;
      addr_nxt = '0;
    end else if (busy_r) begin
      addr_nxt = addr_r + 1'b1;
      if (addr_r == hplh_pkg::ADDR_BITS'(hplh_pkg::DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      addr_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign busy = busy_r;
  assign addr = addr_r;

endmodule

// ----- rtl/homopolymer_length_histogram.sv -----
// Top level of the homopolymer length histogram: request decode, counter RAM
// read-modify-write with forwarding, output register and clearing sequencer.
// Depends on hplh_pkg, hplh_decode, hplh_sweep, hplh_ram.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | input     | in_tvalid/in_tready   | tuser req_type; tdata base..read_len
//  out     | output    | out_tvalid/out_tready | tuser status; tdata count
//  cfg     | input     | cfg_valid/cfg_ready   | cfg_data max_len
//
// One request per cycle while the output takes results and no clear is pending or running.
// The RAM read is registered with the request in stage s1; the count is then incremented,
// written back and registered at the output (back-to-back adds to one counter are forwarded).
// Reset, a clear request and a max_len write run a clearing pass over every counter (one
// counter per cycle on the RAM write port); no request is taken meanwhile. A stalled output holds s1.
module homopolymer_length_histogram (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] base, [17:2] ref_len, [33:18] length_error, [37:34] read_len, [39:38] zero
  input  logic [hplh_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // [1:0] req_type
  input  logic [hplh_pkg::REQ_BITS-1:0]       in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] count
  output logic [hplh_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  // [1:0] status
  output logic [hplh_pkg::STAT_BITS-1:0]      out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hplh_pkg::MAXL_BITS-1:0]      cfg_data
);

  hplh_pkg::dec_t                  dec;
  logic                            in_accept;
  logic                            cfg_accept;
  logic                            sweep_start;
  logic                            sweep_busy;
  logic [hplh_pkg::ADDR_BITS-1:0]  sweep_addr;

  logic [hplh_pkg::MAXL_BITS-1:0]  max_len_r, max_len_nxt;
  logic                            s1_valid_r, s1_valid_nxt;
  hplh_pkg::dec_t                  s1_dec_r, s1_dec_nxt;
  logic                            fwd_valid_r, fwd_valid_nxt;
  logic [hplh_pkg::ADDR_BITS-1:0]  fwd_addr_r, fwd_addr_nxt;
  logic [hplh_pkg::COUNT_BITS-1:0] fwd_data_r, fwd_data_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [hplh_pkg::OUT_BITS-1:0]   out_count_r, out_count_nxt;
  logic [hplh_pkg::STAT_BITS-1:0]  out_status_r, out_status_nxt;

  logic [hplh_pkg::COUNT_BITS-1:0] rd_data;
  logic [hplh_pkg::COUNT_BITS-1:0] cur;
  logic [hplh_pkg::COUNT_BITS-1:0] inc;
  logic                            s1_adv;
  logic                            item_we;
  logic                            ram_we;
  logic [hplh_pkg::ADDR_BITS-1:0]  ram_waddr;
  logic [hplh_pkg::COUNT_BITS-1:0] ram_wdata;

  hplh_decode u_decode (
    .req_type     (in_tuser),
    .base         (in_tdata[1:0]),
    .ref_len      (in_tdata[17:2]),
    .length_error (in_tdata[33:18]),
    .read_len     (in_tdata[37:34]),
    .max_len      (max_len_r),
    .dec          (dec)
  );

  hplh_sweep u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sweep_start),
    .busy  (sweep_busy),
    .addr  (sweep_addr)
  );

  hplh_ram #(
    .WIDTH (hplh_pkg::COUNT_BITS),
    .DEPTH (hplh_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (dec.addr),
    .rdata (rd_data)
  );

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  // a clear in flight blocks intake until its sweep has started
  assign in_tready = !sweep_busy && !(s1_valid_r && s1_dec_r.is_clear)
                   && (!s1_valid_r || s1_adv);
  assign in_accept = in_tvalid && in_tready;

  assign sweep_start = cfg_accept || (s1_adv && s1_dec_r.is_clear);

  // the write of the previous request lands on the same edge as this read
  assign cur = (fwd_valid_r && fwd_addr_r == s1_dec_r.addr) ? fwd_data_r : rd_data;
  assign inc = (cur == {hplh_pkg::COUNT_BITS{1'b1}}) ? cur : cur + 1'b1;

  assign item_we   = s1_adv && s1_dec_r.is_add && s1_dec_r.hit;
  assign ram_we    = item_we || sweep_busy;
  assign ram_waddr = sweep_busy ? sweep_addr : s1_dec_r.addr;
  assign ram_wdata = sweep_busy ? '0 : inc;

  always_comb begin
    max_len_nxt    = cfg_accept ? cfg_data : max_len_r;
    s1_valid_nxt   = s1_valid_r;
    s1_dec_nxt     = s1_dec_r;
    fwd_valid_nxt  = fwd_valid_r;
    fwd_addr_nxt   = fwd_addr_r;
    fwd_data_nxt   = fwd_data_r;
    out_valid_nxt  = out_valid_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      s1_valid_nxt   = 1'b0;
      out_valid_nxt  = 1'b1;
      out_status_nxt = s1_dec_r.status;
      out_count_nxt  = '0;
      if (s1_dec_r.hit) begin
        out_count_nxt = hplh_pkg::OUT_BITS'(s1_dec_r.is_add ? inc : cur);
      end
    end
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
      s1_dec_nxt   = dec;
    end

    if (item_we) begin
      fwd_valid_nxt = 1'b1;
      fwd_addr_nxt  = s1_dec_r.addr;
      fwd_data_nxt  = inc;
    end
    if (sweep_start || sweep_busy) begin
      fwd_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= hplh_pkg::MAX_LEN_RESET;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      max_len_r   <= max_len_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_dec_r     <= s1_dec_nxt;
    fwd_addr_r   <= fwd_addr_nxt;
    fwd_data_r   <= fwd_data_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = out_status_r;

`ifndef ASSERT_OFF
  a_no_intake_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_busy |-> !in_tready)
    else $error("request taken during clearing pass");

  a_no_item_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !(item_we && sweep_busy))
    else $error("counter write collides with clearing pass");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced request produced no result");

  a_add_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    item_we |-> (inc != '0))
    else $error("counter wrapped to zero");
`endif

endmodule

// ----- tb/hplh_hist_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the homopolymer length histogram. It watches the request, result
// and max_len channels, keeps its own copy of the counter table and compares every result.
// Depends on hplh_pkg.
module hplh_hist_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  // [1:0] base, [17:2] ref_len, [33:18] length_error, [37:34] read_len, [39:38] zero
  input  logic [hplh_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // [1:0] req_type
  input  logic [hplh_pkg::REQ_BITS-1:0]       in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] count
  input  logic [hplh_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  // [1:0] status
  input  logic [hplh_pkg::STAT_BITS-1:0]      out_tuser,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [hplh_pkg::MAXL_BITS-1:0]      cfg_data,
  output int                                  mismatches,
  output int                                  outstanding
);
  import hplh_pkg::*;

  typedef struct packed {
    logic [OUT_BITS-1:0]  count;
    logic [STAT_BITS-1:0] status;
  } hist_result_t;

  logic [COUNT_BITS-1:0] tally [4][MAX_HP+1][MAX_HP+1];
  logic [MAXL_BITS-1:0]  max_len_q;
  hist_result_t          due_q[$];
  int                    errs = 0;
  int                    seen = 0;

  function automatic void wipe_tally();
    tally = '{default: '0};
  endfunction

  function automatic hist_result_t predict(
      input logic [REQ_BITS-1:0]          req,
      input logic [BASE_BITS-1:0]         base,
      input logic [LEN_BITS-1:0]          row,
      input logic signed [LEN_BITS-1:0]   err,
      input logic [RDLEN_BITS-1:0]        col);
    hist_result_t res;
    int lim;
    int row_i;
    int err_i;
    int col_i;
    int obs;
    logic [SIDE_BITS-1:0] r_ix;
    logic [SIDE_BITS-1:0] c_ix;
    res   = '0;
    lim   = (int'(max_len_q) < MAX_HP) ? int'(max_len_q) : MAX_HP;
    row_i = int'(row);
    err_i = int'(err);   // sign-extends
    col_i = int'(col);
    r_ix  = SIDE_BITS'(row_i);
    case (req)
      REQ_ADD: begin
        obs = row_i + err_i;
        // row check wins over both observed-length checks
        if (row_i > lim)
          res.status = ST_REF_LONG;
        else if (obs > lim)
          res.status = ST_OBS_LONG;
        else if (obs < 0)
          res.status = ST_OBS_NEG;
        else begin
          c_ix = SIDE_BITS'(obs);
          if (tally[base][r_ix][c_ix] != '1)
            tally[base][r_ix][c_ix] = tally[base][r_ix][c_ix] + 1'b1;
          res.count = tally[base][r_ix][c_ix];
        end
      end
      REQ_READ: begin
        if (row_i > lim)
          res.status = ST_REF_LONG;
        else if (col_i > lim)
          res.status = ST_OBS_LONG;
        else begin
          c_ix = SIDE_BITS'(col_i);
          res.count = tally[base][r_ix][c_ix];
        end
      end
      REQ_CLEAR: wipe_tally();
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    hist_result_t want;
    hist_result_t got;
    if (!rst_n) begin
      max_len_q = MAX_LEN_RESET;
      wipe_tally();
      due_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.count  = out_tdata;
        got.status = out_tuser;
        seen++;
        if (due_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("result %0d: none expected, got count %0d status %0d",
                     seen, got.count, got.status);
        end else begin
          want = due_q.pop_front();
          if (got.count !== want.count || got.status !== want.status) begin
            errs++;
            if (errs <= 10)
              $display("result %0d: expected count %0d status %0d, got count %0d status %0d",
                       seen, want.count, want.status, got.count, got.status);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        max_len_q = cfg_data;
        wipe_tally();
      end
      if (in_tvalid && in_tready)
        due_q.insert(due_q.size(),
                     predict(in_tuser, in_tdata[1:0], in_tdata[17:2], in_tdata[33:18],
                             in_tdata[37:34]));
    end
    mismatches  <= errs;
    outstanding <= due_q.size();
  end

endmodule

// ----- tb/tb_homopolymer_length_histogram.sv -----
`timescale 1ns / 1ps
// Top of the homopolymer length histogram testbench: clock, reset, request and max_len
// stimulus, result back-pressure, watchdog and verdict.
// Depends on hplh_pkg, homopolymer_length_histogram and hplh_hist_checker.
module tb_homopolymer_length_histogram;
  import hplh_pkg::*;

  localparam logic [REQ_BITS-1:0] REQ_SPARE = 2'd3;
  localparam int STALL_LIMIT = 5000;   // covers a full clearing pass with margin

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_DATA_BITS-1:0]   in_tdata;
  logic [REQ_BITS-1:0]       in_tuser;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_DATA_BITS-1:0]  out_tdata;
  logic [STAT_BITS-1:0]      out_tuser;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [MAXL_BITS-1:0]      cfg_data;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  int tx_run_left = 0;
  bit tx_calm;
  int rx_run_left = 0;
  bit rx_calm;

  homopolymer_length_histogram dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  hplh_hist_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // result side: random stalls per result, with stretches of none
  initial begin : result_sink
    int stall;
    forever begin
      if (rx_run_left == 0) begin
        rx_calm     = ($urandom_range(0, 2) == 0);
        rx_run_left = $urandom_range(8, 40);
      end
      rx_run_left--;
      stall = rx_calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // valid stays high into the next request when no gap is drawn
  task automatic send_req(input logic [REQ_BITS-1:0] req, input logic [BASE_BITS-1:0] base,
                          input logic [LEN_BITS-1:0] ref_len,
                          input logic [LEN_BITS-1:0] len_err,
                          input logic [RDLEN_BITS-1:0] read_len);
    int gap;
    if (tx_run_left == 0) begin
      tx_calm     = ($urandom_range(0, 2) == 0);
      tx_run_left = $urandom_range(8, 40);
    end
    tx_run_left--;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, read_len, len_err, ref_len, base};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic set_limit(input logic [MAXL_BITS-1:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly in-range adds and reads, some near the limit edges, some raw noise
  task automatic random_req(input int lim);
    int pick;
    int row_i;
    int obs_i;
    int hot;
    logic [REQ_BITS-1:0]   req;
    logic [BASE_BITS-1:0]  base;
    logic [LEN_BITS-1:0]   ref_len;
    logic [LEN_BITS-1:0]   len_err;
    logic [RDLEN_BITS-1:0] read_len;
    pick     = $urandom_range(0, 99);
    base     = BASE_BITS'($urandom_range(0, 3));
    ref_len  = LEN_BITS'($urandom);
    len_err  = LEN_BITS'($urandom);
    read_len = RDLEN_BITS'($urandom);
    req      = REQ_ADD;
    hot      = (lim < 2) ? lim : 2;
    if (pick < 60) begin
      // half the time stay in a small corner so counters climb
      row_i   = $urandom_range(0, 1) ? $urandom_range(0, lim) : $urandom_range(0, hot);
      obs_i   = $urandom_range(0, 1) ? $urandom_range(0, lim) : $urandom_range(0, hot);
      ref_len = LEN_BITS'(row_i);
      len_err = LEN_BITS'(obs_i - row_i);
    end else if (pick < 80) begin
      req      = REQ_READ;
      ref_len  = LEN_BITS'($urandom_range(0, lim));
      read_len = RDLEN_BITS'($urandom_range(0, lim));
    end else if (pick < 90) begin
      req      = $urandom_range(0, 1) ? REQ_ADD : REQ_READ;
      row_i    = $urandom_range(0, lim + 1);
      obs_i    = $urandom_range(0, lim + 4);
      obs_i   -= 2;
      ref_len  = LEN_BITS'(row_i);
      len_err  = LEN_BITS'(obs_i - row_i);
      read_len = RDLEN_BITS'($urandom_range(0, (lim < 15) ? lim + 1 : 15));
    end else if (pick < 98)
      req = $urandom_range(0, 1) ? REQ_ADD : REQ_READ;
    else if (pick < 99)
      req = REQ_SPARE;
    else
      req = REQ_CLEAR;
    send_req(req, base, ref_len, len_err, read_len);
  endtask

  task automatic run_phase(input logic [MAXL_BITS-1:0] lim, input int n);
    set_limit(lim);
    repeat (n) random_req(int'(lim));
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_ADD;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // limit from reset (15)
    send_req(REQ_ADD,   2'd0, 16'd0,      16'd0,      4'd0);
    send_req(REQ_ADD,   2'd0, 16'd0,      16'd0,      4'd0);
    send_req(REQ_ADD,   2'd3, 16'd15,     16'd0,      4'd0);
    send_req(REQ_ADD,   2'd3, 16'd15,     16'd1,      4'd0);
    send_req(REQ_ADD,   2'd1, 16'd16,     16'd0,      4'd0);
    send_req(REQ_ADD,   2'd2, 16'hFFFF,   16'h7FFF,   4'd0);
    send_req(REQ_ADD,   2'd2, 16'd16,     -16'sd20,   4'd0);  // row check before negative
    send_req(REQ_ADD,   2'd1, 16'd3,      -16'sd4,    4'd0);
    send_req(REQ_ADD,   2'd1, 16'd3,      16'h8000,   4'd0);
    send_req(REQ_ADD,   2'd0, 16'd0,      16'h7FFF,   4'd0);
    send_req(REQ_ADD,   2'd2, 16'd5,      -16'sd5,    4'd0);
    send_req(REQ_ADD,   2'd1, 16'd2,      16'd3,      4'd0);
    send_req(REQ_READ,  2'd0, 16'd0,      16'd0,      4'd0);
    send_req(REQ_READ,  2'd3, 16'd15,     16'd0,      4'd15);
    send_req(REQ_READ,  2'd1, 16'd16,     16'd0,      4'd0);
    send_req(REQ_READ,  2'd0, 16'hFFFF,   16'hFFFF,   4'd15);
    send_req(REQ_READ,  2'd2, 16'd15,     16'd0,      4'd15);
    send_req(REQ_SPARE, 2'd3, 16'hFFFF,   16'hFFFF,   4'd15);
    send_req(REQ_CLEAR, 2'd0, 16'd0,      16'd0,      4'd0);
    send_req(REQ_READ,  2'd0, 16'd0,      16'd0,      4'd0);

    // smallest limit; the write also empties the table
    set_limit(4'd0);
    send_req(REQ_ADD,   2'd0, 16'd0,      16'd0,      4'd0);
    send_req(REQ_ADD,   2'd0, 16'd0,      16'd1,      4'd0);
    send_req(REQ_ADD,   2'd0, 16'd1,      -16'sd1,    4'd0);
    send_req(REQ_READ,  2'd0, 16'd0,      16'd0,      4'd1);
    send_req(REQ_READ,  2'd0, 16'd0,      16'd0,      4'd0);

    run_phase(4'd0,  100);
    run_phase(4'd15, 110);
    run_phase(4'd7,  110);
    run_phase(4'd1,  110);
    run_phase(4'd12, 110);
    run_phase(4'd15, 110);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    #1;
    if (mismatches == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hplh_pkg.sv
rtl/hplh_ram.sv
rtl/hplh_decode.sv
rtl/hplh_sweep.sv
rtl/homopolymer_length_histogram.sv
tb/hplh_hist_checker.sv
tb/tb_homopolymer_length_histogram.sv
